// ===== src/exponential_gain_ramp_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the exponential gain ramp
// Shared property forms; the asserting module must have clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef EXPONENTIAL_GAIN_RAMP_ASSERT_SVH
`define EXPONENTIAL_GAIN_RAMP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define EGR_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("egr assertion failed");

// Next-cycle implication, checked out of reset.
`define EGR_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("egr assertion failed");

`endif

// ===== src/egr_pkg.sv =====
// ----------------------------------------------------------------------------
// egr_pkg
// Types, constants and codes shared by the exponential gain ramp modules.
// ----------------------------------------------------------------------------
`default_nettype none

package egr_pkg;

	// Sizes
	localparam int MAX_CHANNELS   = 8;
	localparam int MAX_FRAME      = 256;
	localparam int SAMPLE_BITS    = 24;
	localparam int GAIN_FRAC_BITS = 30;
	localparam int GAIN_BITS      = 32;
	localparam int CH_W           = $clog2(MAX_CHANNELS);
	localparam int PER_W          = $clog2(MAX_FRAME);
	localparam int CHCFG_W        = 4;
	localparam int FRCFG_W        = 9;
	localparam int QUEUE_DEPTH    = 2;
	localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

	// Volume step to gain: 2^F = 255 * VOL_QUO + VOL_REM
	localparam logic [GAIN_BITS-1:0] VOL_QUO = GAIN_BITS'((64'd1 << GAIN_FRAC_BITS) / 255);
	localparam logic [7:0]           VOL_REM = 8'((64'd1 << GAIN_FRAC_BITS) % 255);

	// Register reset values
	localparam logic [GAIN_BITS-1:0] UP_FACTOR_RST   = 32'd1073762976;
	localparam logic [GAIN_BITS-1:0] DOWN_FACTOR_RST = 32'd1073720672;
	localparam logic [GAIN_BITS-1:0] MIN_GAIN_RST    = 32'd10737418;
	localparam logic [GAIN_BITS-1:0] SNAP_RST        = 32'd1073742;
	localparam logic [CHCFG_W-1:0]   CHANNELS_RST    = 4'd2;
	localparam logic [FRCFG_W-1:0]   FRAME_RST       = 9'd64;
	localparam logic [GAIN_BITS-1:0] GAIN_ONE        = GAIN_BITS'(64'd1 << GAIN_FRAC_BITS);

	// Operation codes
	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_VOLUME = 2'd1,
		OP_MUTE   = 2'd2
	} op_t;

	// Frame ramp mode
	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_UP   = 2'd1,
		MODE_DOWN = 2'd2
	} mode_t;

	// Register indexes
	typedef enum logic [2:0] {
		REG_UP_FACTOR   = 3'd0,
		REG_DOWN_FACTOR = 3'd1,
		REG_MIN_GAIN    = 3'd2,
		REG_SNAP        = 3'd3,
		REG_INIT_GAIN   = 3'd4,
		REG_CHANNELS    = 3'd5,
		REG_FRAME       = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]                    operation;
		logic signed [SAMPLE_BITS-1:0] sample_in;
		logic [7:0]                    volume_step;
		logic                          mute_request;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_out;
		logic [2:0]                    channel_index;
		logic                          frame_last;
		logic [1:0]                    ramp_status;
	} out_item_t;

	// Classified request between front and back
	typedef struct packed {
		op_t                  kind;
		logic [GAIN_BITS-1:0] payload;
	} q_ent_t;

	// Queue status toward both sides
	typedef struct packed {
		logic full;
		logic not_empty;
	} q_stat_t;

endpackage

`default_nettype wire

// ===== src/egr_front.sv =====
// ----------------------------------------------------------------------------
// egr_front
// Accepts input requests, drops unknown codes, turns volume steps into gains.
// ----------------------------------------------------------------------------
`default_nettype none

module egr_front import egr_pkg::*; (
	input  wire in_item_t in_data,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire q_stat_t  q_stat,
	output logic          push,
	output q_ent_t        push_ent
);

	logic [GAIN_BITS-1:0] vol_base;
	logic [15:0]          vol_rem;
	logic [23:0]          vol_qprod;
	logic [GAIN_BITS-1:0] vol_gain;

	// Volume gain: step*VOL_QUO + floor((step*VOL_REM + 127) / 255)
	always_comb begin
		vol_base  = GAIN_BITS'(in_data.volume_step) * VOL_QUO;
		vol_rem   = 16'(in_data.volume_step) * 16'(VOL_REM) + 16'd127;
		vol_qprod = (24'(vol_rem) + 24'd1) * 24'd257;
		vol_gain  = vol_base + GAIN_BITS'(vol_qprod[23:16]);
	end

	// Hold off the source while the queue is full
	assign in_stall = q_stat.full;

	// Classify the request
	always_comb begin
		push             = 1'b0;
		push_ent.kind    = OP_SAMPLE;
		push_ent.payload = GAIN_BITS'($unsigned(in_data.sample_in));
		case (in_data.operation)
			OP_SAMPLE: begin
				push = in_valid && !q_stat.full;
			end
			OP_VOLUME: begin
				push             = in_valid && !q_stat.full;
				push_ent.kind    = OP_VOLUME;
				push_ent.payload = vol_gain;
			end
			OP_MUTE: begin
				push             = in_valid && !q_stat.full;
				push_ent.kind    = OP_MUTE;
				push_ent.payload = GAIN_BITS'(in_data.mute_request);
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/egr_queue.sv =====
// ----------------------------------------------------------------------------
// egr_queue
// Short request queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module egr_queue import egr_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire logic   push,
	input  wire q_ent_t push_ent,
	input  wire logic   pop,
	output q_ent_t      head,
	output q_stat_t     stat
);

	q_ent_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head           = mem_q[rd_ptr_q];
	assign stat.full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.not_empty = (count_q != '0);

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_ent;
		end
	end

endmodule

`default_nettype wire

// ===== src/egr_back.sv =====
// ----------------------------------------------------------------------------
// egr_back
// Gain state, frame ramp control, shared multiplier and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module egr_back import egr_pkg::*; (
	input  wire             clk,
	input  wire             arst_n,
	input  wire logic       cfg_valid,
	input  wire logic [2:0] cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire q_ent_t     head,
	input  wire q_stat_t    q_stat,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_stall,
	output out_item_t       out_data
);

	`include "exponential_gain_ramp_assert.svh"

	localparam int PROD_W = 2 * GAIN_BITS;
	localparam int RND_W  = PROD_W - GAIN_FRAC_BITS;
	localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (GAIN_FRAC_BITS - 1);
	localparam logic [RND_W-1:0]  NEG_LIM  = RND_W'(1) << (SAMPLE_BITS - 1);
	localparam logic [RND_W-1:0]  POS_LIM  = NEG_LIM - 1'b1;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DECIDE = 6'b000010,
		ST_GMUL   = 6'b000100,
		ST_GRND   = 6'b001000,
		ST_SMUL   = 6'b010000,
		ST_OUT    = 6'b100000
	} state_t;

	state_t               state_q;
	logic [GAIN_BITS-1:0] up_q, down_q, min_q, snap_q;
	logic [CHCFG_W-1:0]   channels_q;
	logic [FRCFG_W-1:0]   frames_q;
	logic [GAIN_BITS-1:0] cur_q, target_q, stored_q;
	mode_t                mode_q;
	logic [CH_W-1:0]      ch_pos_q;
	logic [PER_W-1:0]     per_pos_q;
	logic                 out_valid_q;
	out_item_t            out_q;
	logic [PROD_W-1:0]    prod_q;
	logic [SAMPLE_BITS-1:0] mag_q;
	logic                 neg_q;

	logic [CHCFG_W-1:0]   nch;
	logic [FRCFG_W-1:0]   nfr;
	logic                 last_ch, last_fr, frame_start, out_free;
	logic [GAIN_BITS-1:0] diff, init_gain;
	mode_t                mode_n;
	logic [GAIN_BITS-1:0] mul_a, mul_b;
	logic [PROD_W-1:0]    prod, rsum;
	logic [RND_W-1:0]     rval, rclamp;
	logic [GAIN_BITS-1:0] gain_rnd;
	logic [SAMPLE_BITS-1:0] samp_rnd, head_samp;

	// Effective counts
	always_comb begin
		if (channels_q == '0) begin
			nch = CHCFG_W'(1);
		end else if (channels_q > CHCFG_W'(MAX_CHANNELS)) begin
			nch = CHCFG_W'(MAX_CHANNELS);
		end else begin
			nch = channels_q;
		end
		if (frames_q == '0) begin
			nfr = FRCFG_W'(1);
		end else if (frames_q > FRCFG_W'(MAX_FRAME)) begin
			nfr = FRCFG_W'(MAX_FRAME);
		end else begin
			nfr = frames_q;
		end
		last_ch     = (CHCFG_W'(ch_pos_q) + 1'b1) >= nch;
		last_fr     = last_ch && ((FRCFG_W'(per_pos_q) + 1'b1) >= nfr);
		frame_start = (ch_pos_q == '0) && (per_pos_q == '0);
	end

	// Frame decision against the latched target
	always_comb begin
		diff = (target_q >= cur_q) ? target_q - cur_q : cur_q - target_q;
		if (diff <= snap_q) begin
			mode_n = MODE_IDLE;
		end else if (target_q > cur_q) begin
			mode_n = MODE_UP;
		end else begin
			mode_n = MODE_DOWN;
		end
		init_gain = (cfg_data > min_q) ? cfg_data : min_q;
		head_samp = head.payload[SAMPLE_BITS-1:0];
	end

	// Shared multiplier and rounding
	always_comb begin
		if (state_q == ST_GMUL) begin
			mul_a = cur_q;
			mul_b = (mode_q == MODE_UP) ? up_q : down_q;
		end else begin
			mul_a = GAIN_BITS'(mag_q);
			mul_b = cur_q;
		end
		prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
		rsum     = prod_q + RND_HALF;
		rval     = rsum[PROD_W-1:GAIN_FRAC_BITS];
		gain_rnd = (rval > RND_W'({GAIN_BITS{1'b1}})) ? '1 : GAIN_BITS'(rval);
		if (neg_q) begin
			rclamp   = (rval > NEG_LIM) ? NEG_LIM : rval;
			samp_rnd = SAMPLE_BITS'(~rclamp + 1'b1);
		end else begin
			rclamp   = (rval > POS_LIM) ? POS_LIM : rval;
			samp_rnd = SAMPLE_BITS'(rclamp);
		end
	end

	assign pop       = (state_q == ST_IDLE) && q_stat.not_empty;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Control and gain state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			up_q        <= UP_FACTOR_RST;
			down_q      <= DOWN_FACTOR_RST;
			min_q       <= MIN_GAIN_RST;
			snap_q      <= SNAP_RST;
			channels_q  <= CHANNELS_RST;
			frames_q    <= FRAME_RST;
			cur_q       <= GAIN_ONE;
			target_q    <= GAIN_ONE;
			stored_q    <= GAIN_ONE;
			mode_q      <= MODE_IDLE;
			ch_pos_q    <= '0;
			per_pos_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Drop the result once taken, unless a new one loads now
			if (out_valid_q && !out_stall && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_stat.not_empty) begin
						case (head.kind)
							OP_VOLUME: begin
								stored_q <= head.payload;
								target_q <= head.payload;
							end
							OP_MUTE: begin
								target_q <= head.payload[0] ? '0 : stored_q;
							end
							OP_SAMPLE: begin
								state_q <= ST_DECIDE;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_DECIDE: begin
					if (frame_start) begin
						mode_q <= mode_n;
						if (mode_n == MODE_IDLE) begin
							cur_q <= target_q;
						end else if (mode_n == MODE_UP && cur_q < min_q) begin
							cur_q <= min_q;
						end
					end
					if ((ch_pos_q == '0) && ((frame_start ? mode_n : mode_q) != MODE_IDLE)) begin
						state_q <= ST_GMUL;
					end else begin
						state_q <= ST_SMUL;
					end
				end
				ST_GMUL: begin
					state_q <= ST_GRND;
				end
				ST_GRND: begin
					cur_q   <= gain_rnd;
					state_q <= ST_SMUL;
				end
				ST_SMUL: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (last_ch) begin
							ch_pos_q  <= '0;
							per_pos_q <= last_fr ? '0 : per_pos_q + 1'b1;
						end else begin
							ch_pos_q <= ch_pos_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// Register writes must arrive only while idle; the block itself does not enforce this
			if (cfg_valid) begin
				case (cfg_index)
					REG_UP_FACTOR:   up_q       <= cfg_data;
					REG_DOWN_FACTOR: down_q     <= cfg_data;
					REG_MIN_GAIN:    min_q      <= cfg_data;
					REG_SNAP:        snap_q     <= cfg_data;
					REG_INIT_GAIN: begin
						cur_q    <= init_gain;
						target_q <= init_gain;
						stored_q <= init_gain;
					end
					REG_CHANNELS:    channels_q <= cfg_data[CHCFG_W-1:0];
					REG_FRAME:       frames_q   <= cfg_data[FRCFG_W-1:0];
					default: begin
						up_q <= up_q;
					end
				endcase
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (pop && head.kind == OP_SAMPLE) begin
			neg_q <= head_samp[SAMPLE_BITS-1];
			mag_q <= head_samp[SAMPLE_BITS-1] ? ~head_samp + 1'b1 : head_samp;
		end
		if (state_q == ST_GMUL || state_q == ST_SMUL) begin
			prod_q <= prod;
		end
		if (state_q == ST_OUT && out_free) begin
			out_q.sample_out    <= samp_rnd;
			out_q.channel_index <= 3'(ch_pos_q);
			out_q.frame_last    <= last_fr;
			out_q.ramp_status   <= mode_q;
		end
	end

	`EGR_ASSERT_NEXT(a_gmul_to_grnd, state_q == ST_GMUL, state_q == ST_GRND)
	`EGR_ASSERT_NEXT(a_smul_to_out, state_q == ST_SMUL, state_q == ST_OUT)
	`EGR_ASSERT_NEXT(a_frame_wrap, state_q == ST_OUT && out_free && last_fr,
		ch_pos_q == '0 && per_pos_q == '0 && out_valid_q)
	`EGR_ASSERT_IMPL(a_pop_only_idle, pop, state_q == ST_IDLE && q_stat.not_empty)

endmodule

`default_nettype wire

// ===== src/exponential_gain_ramp.sv =====
// ----------------------------------------------------------------------------
// exponential_gain_ramp
// Smoothed per-frame gain with exponential ramps and mute for interleaved
// multichannel audio samples.
//
//   Channel  Signals                                  Handshake
//   in       in_valid, in_stall, in_data              valid high, stall low
//   out      out_valid, out_stall, out_data           valid high, stall low
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data valid and ready high
//
// A sample passes through the back-end states pop, frame decision, multiply
// and output; at the first channel of a ramping period the one shared 32x32
// multiplier first updates the gain. Volume and mute requests act at the pop.
// A two-entry queue keeps the input open while the back end works or the
// output register waits on out_stall. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module exponential_gain_ramp import egr_pkg::*; (
	input  wire              clk,
	input  wire              arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_item_t        out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	logic    push;
	logic    pop;
	q_ent_t  push_ent;
	q_ent_t  head;
	q_stat_t q_stat;

	// Register writes never wait
	assign cfg_ready = 1'b1;

	egr_front u_front (
		.in_data  (in_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.q_stat   (q_stat),
		.push     (push),
		.push_ent (push_ent)
	);

	egr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	egr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ===== sim/gain_ramp_checker.sv =====
// ----------------------------------------------------------------------------
// gain_ramp_checker
// Watches the request, result and register channels of the gain ramp. Keeps
// its own copy of the gain state and registers, works out the gained sample
// for every accepted sample request and compares it field by field with the
// results that leave the block, oldest first.
// ----------------------------------------------------------------------------
module gain_ramp_checker import egr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire in_item_t    in_data,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire out_item_t   out_data,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output int               mismatches,
	output int               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] HALF_LSB  = 64'd1 << (GAIN_FRAC_BITS - 1);
	localparam logic [63:0] SAT_NEG   = 64'd1 << (SAMPLE_BITS - 1);
	localparam logic [63:0] SAT_POS   = SAT_NEG - 64'd1;
	localparam logic [63:0] GAIN_SAT  = 64'hFFFF_FFFF;
	localparam int          PRINT_CAP = 100;

	// Register copy
	logic [GAIN_BITS-1:0] up_f, down_f, floor_gain, snap_dist;
	logic [CHCFG_W-1:0]   chan_cfg;
	logic [FRCFG_W-1:0]   frame_cfg;

	// Gain state copy
	logic [GAIN_BITS-1:0] cur_gain, aim_gain, kept_gain, frm_gain;
	mode_t                frm_mode;
	int unsigned          ch_pos, per_pos;
	logic                 is_muted;

	out_item_t gained_q[$];
	out_item_t head;

	// Gain times factor, rounded half up, saturated to 32 bits
	function automatic logic [GAIN_BITS-1:0] scale_gain(logic [GAIN_BITS-1:0] g,
			logic [GAIN_BITS-1:0] f);
		logic [63:0] p;
		p = (64'(g) * 64'(f) + HALF_LSB) >> GAIN_FRAC_BITS;
		return (p > GAIN_SAT) ? GAIN_SAT[31:0] : p[31:0];
	endfunction

	// Sample times gain on the magnitude, rounded half away from zero, saturated
	function automatic logic [SAMPLE_BITS-1:0] gain_sample(logic [SAMPLE_BITS-1:0] raw,
			logic [GAIN_BITS-1:0] g);
		logic        neg;
		logic [63:0] mag, m;
		neg = raw[SAMPLE_BITS-1];
		mag = neg ? (64'd1 << SAMPLE_BITS) - 64'(raw) : 64'(raw);
		m = (mag * 64'(g) + HALF_LSB) >> GAIN_FRAC_BITS;
		if (neg) begin
			if (m > SAT_NEG)
				m = SAT_NEG;
			return SAMPLE_BITS'((64'd1 << SAMPLE_BITS) - m);
		end
		if (m > SAT_POS)
			m = SAT_POS;
		return SAMPLE_BITS'(m);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < PRINT_CAP)
			$display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
		mismatches++;
	endtask

	// Advance the gain state by one request; queue the result of a sample
	task automatic take_request(input in_item_t req);
		int unsigned          nch, nfr;
		logic [GAIN_BITS-1:0] diff;
		logic                 last_ch, last_fr;
		out_item_t            res;
		case (req.operation)
			OP_VOLUME: begin
				kept_gain = 32'(((64'(req.volume_step) << GAIN_FRAC_BITS) + 64'd127) / 64'd255);
				aim_gain = kept_gain;
			end
			OP_MUTE: begin
				is_muted = req.mute_request;
				aim_gain = is_muted ? '0 : kept_gain;
			end
			OP_SAMPLE: begin
				nch = (chan_cfg == 0) ? 1 : ((chan_cfg > MAX_CHANNELS) ? MAX_CHANNELS : chan_cfg);
				nfr = (frame_cfg == 0) ? 1 : ((frame_cfg > MAX_FRAME) ? MAX_FRAME : frame_cfg);
				// latch the target and pick the frame mode
				if (ch_pos == 0 && per_pos == 0) begin
					frm_gain = aim_gain;
					diff = (frm_gain >= cur_gain) ? frm_gain - cur_gain : cur_gain - frm_gain;
					if (diff <= snap_dist) begin
						cur_gain = frm_gain;
						frm_mode = MODE_IDLE;
					end else if (frm_gain > cur_gain) begin
						frm_mode = MODE_UP;
						if (cur_gain < floor_gain)
							cur_gain = floor_gain;
					end else begin
						frm_mode = MODE_DOWN;
					end
				end
				// step the gain once per sample period
				if (ch_pos == 0) begin
					if (frm_mode == MODE_UP)
						cur_gain = scale_gain(cur_gain, up_f);
					else if (frm_mode == MODE_DOWN)
						cur_gain = scale_gain(cur_gain, down_f);
				end
				last_ch = (ch_pos + 1 >= nch);
				last_fr = last_ch && (per_pos + 1 >= nfr);
				res.sample_out    = gain_sample(req.sample_in, cur_gain);
				res.channel_index = 3'(ch_pos);
				res.frame_last    = last_fr;
				res.ramp_status   = frm_mode;
				gained_q.push_back(res);
				if (last_ch) begin
					ch_pos = 0;
					per_pos = last_fr ? 0 : per_pos + 1;
				end else begin
					ch_pos++;
				end
			end
			default: ;
		endcase
	endtask

	task automatic write_register(input logic [2:0] idx, input logic [31:0] v);
		logic [GAIN_BITS-1:0] g;
		case (idx)
			REG_UP_FACTOR:   up_f = v;
			REG_DOWN_FACTOR: down_f = v;
			REG_MIN_GAIN:    floor_gain = v;
			REG_SNAP:        snap_dist = v;
			REG_INIT_GAIN: begin
				g = (v > floor_gain) ? v : floor_gain;
				cur_gain = g;
				aim_gain = g;
				kept_gain = g;
				frm_gain = g;
				is_muted = 1'b0;
			end
			REG_CHANNELS:    chan_cfg = v[CHCFG_W-1:0];
			REG_FRAME:       frame_cfg = v[FRCFG_W-1:0];
			default: ;
		endcase
	endtask

	// Compare results, then fold in new requests and register writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_f = UP_FACTOR_RST;
			down_f = DOWN_FACTOR_RST;
			floor_gain = MIN_GAIN_RST;
			snap_dist = SNAP_RST;
			chan_cfg = CHANNELS_RST;
			frame_cfg = FRAME_RST;
			cur_gain = GAIN_ONE;
			aim_gain = GAIN_ONE;
			kept_gain = GAIN_ONE;
			frm_gain = GAIN_ONE;
			frm_mode = MODE_IDLE;
			ch_pos = 0;
			per_pos = 0;
			is_muted = 1'b0;
			gained_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (gained_q.size() == 0) begin
					report_mismatch("result with nothing pending", 32'(out_data), '0);
				end else begin
					head = gained_q.pop_front();
					if (out_data.sample_out !== head.sample_out)
						report_mismatch("sample_out", 32'(out_data.sample_out),
							32'(head.sample_out));
					if (out_data.channel_index !== head.channel_index)
						report_mismatch("channel_index", 32'(out_data.channel_index),
							32'(head.channel_index));
					if (out_data.frame_last !== head.frame_last)
						report_mismatch("frame_last", 32'(out_data.frame_last),
							32'(head.frame_last));
					if (out_data.ramp_status !== head.ramp_status)
						report_mismatch("ramp_status", 32'(out_data.ramp_status),
							32'(head.ramp_status));
				end
			end
			if (in_valid && !in_stall)
				take_request(in_data);
			if (cfg_valid && cfg_ready)
				write_register(cfg_index, cfg_data);
		end
		outstanding = gained_q.size();
	end

endmodule

// ===== sim/tb_exponential_gain_ramp.sv =====
// ----------------------------------------------------------------------------
// tb_exponential_gain_ramp
// Drives the gain ramp with a short directed run, then random sample, volume
// and mute requests over a series of register settings and idle patterns,
// including a long result hold-off. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_exponential_gain_ramp import egr_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         WATCHDOG_LIMIT = 4000;
	localparam int         DRAIN_CYCLES   = 20;
	localparam int         HOLD_CYCLES    = 400;
	localparam int         PHASE_ITEMS    = 160;
	localparam logic [1:0] OP_RESERVED    = 2'd3;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	in_item_t    in_data   = '0;
	logic        in_stall;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_UP_FACTOR;
	logic [31:0] cfg_data  = '0;

	int mismatches;
	int outstanding;
	int src_idle_pct   = 20;
	int sink_stall_pct = 60;
	int hold_asked     = 0;
	int hold_seen      = 0;
	int hold_left      = 0;
	int quiet          = 0;

	exponential_gain_ramp dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	gain_ramp_checker ramp_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Drive the result stall: a long hold when asked, else random
	always @(negedge clk) begin
		if (hold_asked != hold_seen) begin
			hold_seen = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < sink_stall_pct);
		end
	end

	// End the run when no request moves on any channel for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("watchdog: no request moved for %0d cycles", quiet);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic in_item_t make_req(logic [1:0] op, logic [SAMPLE_BITS-1:0] s,
			logic [7:0] v, logic m);
		in_item_t r;
		r.operation    = op;
		r.sample_in    = s;
		r.volume_step  = v;
		r.mute_request = m;
		return r;
	endfunction

	// Mostly samples, some volume and mute changes, a few reserved codes
	function automatic in_item_t rand_request();
		in_item_t    r;
		int unsigned pick;
		r.sample_in    = SAMPLE_BITS'($urandom);
		r.volume_step  = 8'($urandom);
		r.mute_request = 1'($urandom);
		if ($urandom_range(99) < 8) begin
			case ($urandom_range(3))
				0: r.sample_in = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
				1: r.sample_in = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
				2: r.sample_in = '0;
				default: r.sample_in = '1;
			endcase
		end
		pick = $urandom_range(99);
		if (pick < 80)
			r.operation = OP_SAMPLE;
		else if (pick < 88)
			r.operation = OP_VOLUME;
		else if (pick < 96)
			r.operation = OP_MUTE;
		else
			r.operation = OP_RESERVED;
		return r;
	endfunction

	// Offer one request, idling first at random; hold it until taken
	task automatic offer(input in_item_t req);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic run_random(input int count);
		repeat (count)
			offer(rand_request());
	endtask

	// Leave cfg_valid high; the caller drops it after the last write
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Stop offering, wait for every result, then let queued updates settle
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	initial begin
		repeat (3)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: doubling and halving ramps, one-period frames
		write_reg(REG_UP_FACTOR, 32'h8000_0000);
		write_reg(REG_DOWN_FACTOR, 32'h2000_0000);
		write_reg(REG_MIN_GAIN, 32'h0800_0000);
		write_reg(REG_SNAP, 32'h0010_0000);
		write_reg(REG_CHANNELS, {28'($urandom), 4'd2});
		write_reg(REG_FRAME, {23'($urandom), 9'd1});
		cfg_valid <= 1'b0;
		offer(make_req(OP_SAMPLE, 24'h7F_FFFF, 8'd0, 1'b0));
		offer(make_req(OP_SAMPLE, 24'h80_0000, 8'd0, 1'b0));
		offer(make_req(OP_VOLUME, 24'h00_0000, 8'd0, 1'b0));
		offer(make_req(OP_SAMPLE, 24'h7F_FFFF, 8'd0, 1'b0));
		offer(make_req(OP_SAMPLE, 24'hFF_FFFF, 8'd0, 1'b0));
		offer(make_req(OP_MUTE, 24'h00_0000, 8'd0, 1'b1));
		offer(make_req(OP_SAMPLE, 24'h00_0001, 8'd0, 1'b0));
		offer(make_req(OP_SAMPLE, 24'h80_0000, 8'd0, 1'b0));
		// volume while muted ends the mute in effect
		offer(make_req(OP_VOLUME, 24'h00_0000, 8'd128, 1'b1));
		offer(make_req(OP_SAMPLE, 24'h40_0000, 8'd0, 1'b0));
		offer(make_req(OP_SAMPLE, 24'hC0_0000, 8'd0, 1'b0));
		offer(make_req(OP_MUTE, 24'h00_0000, 8'd0, 1'b0));
		offer(make_req(OP_SAMPLE, 24'h7F_FFFF, 8'd0, 1'b0));
		offer(make_req(OP_SAMPLE, 24'h80_0000, 8'd0, 1'b0));
		offer(make_req(OP_RESERVED, 24'h12_3456, 8'd255, 1'b1));
		offer(make_req(OP_VOLUME, 24'h00_0000, 8'd255, 1'b0));
		offer(make_req(OP_SAMPLE, 24'h7F_FFFF, 8'd0, 1'b0));
		offer(make_req(OP_SAMPLE, 24'h80_0000, 8'd0, 1'b0));
		offer(make_req(OP_SAMPLE, 24'h00_0000, 8'd0, 1'b0));
		offer(make_req(OP_SAMPLE, 24'hFF_FFFF, 8'd0, 1'b0));
		drain();

		// Moderate ramps, short frames
		write_reg(REG_UP_FACTOR, 32'h4400_0000);
		write_reg(REG_DOWN_FACTOR, 32'h3800_0000);
		write_reg(REG_MIN_GAIN, 32'h0400_0000);
		write_reg(REG_SNAP, 32'h0040_0000);
		write_reg(REG_INIT_GAIN, GAIN_ONE);
		write_reg(REG_FRAME, {23'($urandom), 9'd4});
		cfg_valid <= 1'b0;
		run_random(PHASE_ITEMS);
		drain();

		// Extreme factors: gain saturates up, collapses down
		write_reg(REG_MIN_GAIN, 32'h1000_0000);
		write_reg(REG_INIT_GAIN, 32'h0000_0000);
		write_reg(REG_UP_FACTOR, 32'hFFFF_FFFF);
		write_reg(REG_DOWN_FACTOR, 32'h0000_0000);
		write_reg(REG_SNAP, 32'h0000_0000);
		write_reg(REG_CHANNELS, {28'($urandom), 4'd8});
		write_reg(REG_FRAME, {23'($urandom), 9'd3});
		cfg_valid <= 1'b0;
		run_random(PHASE_ITEMS);
		drain();

		// Zero counts act as one; snap always, largest floor
		write_reg(REG_SNAP, 32'hFFFF_FFFF);
		write_reg(REG_MIN_GAIN, 32'hFFFF_FFFF);
		write_reg(REG_INIT_GAIN, 32'hFFFF_FFFF);
		write_reg(REG_CHANNELS, {28'($urandom), 4'd0});
		write_reg(REG_FRAME, {23'($urandom), 9'd0});
		cfg_valid <= 1'b0;
		run_random(PHASE_ITEMS);
		drain();

		// Swap the idle pattern; oversize counts clamp to the maximum
		src_idle_pct = 60;
		sink_stall_pct = 20;
		write_reg(REG_UP_FACTOR, UP_FACTOR_RST);
		write_reg(REG_DOWN_FACTOR, DOWN_FACTOR_RST);
		write_reg(REG_MIN_GAIN, MIN_GAIN_RST);
		write_reg(REG_SNAP, SNAP_RST);
		write_reg(REG_INIT_GAIN, GAIN_ONE);
		write_reg(REG_CHANNELS, {28'($urandom), 4'd15});
		write_reg(REG_FRAME, {23'($urandom), 9'd511});
		cfg_valid <= 1'b0;
		run_random(PHASE_ITEMS);
		drain();

		// Shrink the counts mid-frame so positions wrap early
		write_reg(REG_CHANNELS, {28'($urandom), 4'd3});
		write_reg(REG_FRAME, {23'($urandom), 9'd5});
		write_reg(REG_UP_FACTOR, 32'h4800_0000);
		write_reg(REG_DOWN_FACTOR, 32'h3000_0000);
		write_reg(REG_MIN_GAIN, 32'h1000_0000);
		write_reg(REG_SNAP, 32'h0020_0000);
		cfg_valid <= 1'b0;
		run_random(PHASE_ITEMS);
		drain();

		// Single channel, longest frame
		write_reg(REG_CHANNELS, {28'($urandom), 4'd1});
		write_reg(REG_FRAME, {23'($urandom), 9'd256});
		cfg_valid <= 1'b0;
		run_random(PHASE_ITEMS);
		drain();

		// No idling from here; random settings, gain reloaded mid-frame
		src_idle_pct = 0;
		sink_stall_pct = 0;
		write_reg(REG_UP_FACTOR, $urandom_range(32'h4000_0000, 32'h5000_0000));
		write_reg(REG_DOWN_FACTOR, $urandom_range(32'h3000_0000, 32'h4000_0000));
		write_reg(REG_MIN_GAIN, $urandom_range(0, 32'h1000_0000));
		write_reg(REG_SNAP, $urandom_range(0, 32'h0080_0000));
		write_reg(REG_INIT_GAIN, $urandom);
		write_reg(REG_CHANNELS, {28'($urandom), 4'd5});
		write_reg(REG_FRAME, {23'($urandom), 9'd2});
		cfg_valid <= 1'b0;
		run_random(PHASE_ITEMS);
		drain();

		// No floor, gentle ramps
		write_reg(REG_MIN_GAIN, 32'h0000_0000);
		write_reg(REG_UP_FACTOR, 32'h4200_0000);
		write_reg(REG_DOWN_FACTOR, 32'h3C00_0000);
		write_reg(REG_SNAP, 32'h0008_0000);
		write_reg(REG_CHANNELS, {28'($urandom), 4'd6});
		write_reg(REG_FRAME, {23'($urandom), 9'd7});
		cfg_valid <= 1'b0;
		run_random(PHASE_ITEMS);
		drain();

		// Hold results off long enough to back up the input
		write_reg(REG_CHANNELS, {28'($urandom), 4'd8});
		write_reg(REG_FRAME, {23'($urandom), 9'd1});
		write_reg(REG_UP_FACTOR, 32'h8000_0000);
		write_reg(REG_DOWN_FACTOR, 32'h1000_0000);
		cfg_valid <= 1'b0;
		hold_asked++;
		run_random(PHASE_ITEMS);
		drain();

		if (mismatches == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== exponential_gain_ramp.f =====
+incdir+src
src/egr_pkg.sv
src/egr_front.sv
src/egr_queue.sv
src/egr_back.sv
src/exponential_gain_ramp.sv
sim/gain_ramp_checker.sv
sim/tb_exponential_gain_ramp.sv
